>>> src/diamond_neighbourhood_mean_blur_defines.svh
// ----------------------------------------------------------------------------
// diamond_neighbourhood_mean_blur_defines
// assertion macros shared by the blur rtl
// ----------------------------------------------------------------------------
`ifndef DIAMOND_NEIGHBOURHOOD_MEAN_BLUR_DEFINES_SVH
`define DIAMOND_NEIGHBOURHOOD_MEAN_BLUR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DNMB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DNMB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dnmb_pkg.sv
// ----------------------------------------------------------------------------
// dnmb_pkg
// widths, reset values and register indexes of the diamond mean blur
// ----------------------------------------------------------------------------
package dnmb_pkg;

    localparam int unsigned MAX_SIDE_DEFAULT = 8;
    localparam int unsigned PIXEL_W          = 16;
    localparam int unsigned CFG_W            = 4;
    localparam int unsigned CFG_IDX_W        = 1;
    localparam int unsigned LOAD_W           = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    localparam logic [CFG_W-1:0] SIDE_RESET = 4'd8;

endpackage

>>> src/diamond_neighbourhood_mean_blur.sv
// ----------------------------------------------------------------------------
// diamond_neighbourhood_mean_blur
// stores one region in raster order, then emits the rounded mean of every
// diamond (manhattan distance) neighbourhood, one result per position
// ----------------------------------------------------------------------------
// load: one pixel per cycle, s_ready high whenever the block is loading
// compute: each result is a memory scan over the region, a flush, the restoring
//   divider with one quotient bit per cycle, then emit, which waits while an
//   unaccepted result is still held; SUM_W = 22 at MAX_SIDE 8
// no new pixels are taken until the last result of the region is emitted
// reset: synchronous active-low aresetn clears control, the load count and the
//   output valid; sizes reset to 8; the region memory is not cleared
module diamond_neighbourhood_mean_blur #(
    parameter int unsigned MAX_SIDE = dnmb_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [dnmb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dnmb_pkg::CFG_W-1:0]      cfg_data,
    // pixel requests
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dnmb_pkg::PIXEL_W-1:0]    s_pixel,
    // result requests
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dnmb_pkg::PIXEL_W-1:0]    m_average,
    output logic                            m_is_last
);
    import dnmb_pkg::*;

`include "diamond_neighbourhood_mean_blur_defines.svh"

    // derived sizes
    localparam int unsigned DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned SW     = $clog2(MAX_SIDE);
    localparam int unsigned SZW    = $clog2(MAX_SIDE + 1);
    localparam int unsigned DIST_W = SZW + 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W  = PIXEL_W + AW;
    localparam int unsigned STEP_W = $clog2(SUM_W);

    // sequencer states
    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // region memory, one write port while loading, one registered read port
    logic [PIXEL_W-1:0] region_mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;
    logic               mem_we;

    // configuration registers
    logic [CFG_W-1:0] cfg_rows_reg;
    logic [CFG_W-1:0] cfg_cols_reg;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [LOAD_W-1:0] load_count_reg, load_count_next;
    logic [SZW-1:0]    rows_reg, rows_next;
    logic [SZW-1:0]    cols_reg, cols_next;
    logic [SZW-1:0]    d_reg, d_next;
    logic [SW-1:0]     r_reg, r_next;
    logic [SW-1:0]     c_reg, c_next;
    logic [SW-1:0]     rr_reg, rr_next;
    logic [SW-1:0]     cc_reg, cc_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    // datapath registers
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   den_reg, den_next;
    logic [PIXEL_W-1:0] m_average_reg, m_average_next;
    logic               m_is_last_reg, m_is_last_next;

    // combinational helpers
    logic [SZW-1:0]    rows_eff, cols_eff;
    logic [LOAD_W-1:0] n_eff;
    logic [LOAD_W-1:0] load_inc;
    logic [SW-1:0]     dr, dc;
    logic [DIST_W-1:0] man_dist;
    logic              inner_last, pos_last, emit_fire;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  cnt_acc;
    logic [CNT_W:0]    trial;

    // a size of zero acts as one, a size above MAX_SIDE saturates
    always_comb begin
        if (cfg_rows_reg == '0) begin
            rows_eff = SZW'(1);
        end else if (cfg_rows_reg > CFG_W'(MAX_SIDE)) begin
            rows_eff = SZW'(MAX_SIDE);
        end else begin
            rows_eff = SZW'(cfg_rows_reg);
        end
        if (cfg_cols_reg == '0) begin
            cols_eff = SZW'(1);
        end else if (cfg_cols_reg > CFG_W'(MAX_SIDE)) begin
            cols_eff = SZW'(MAX_SIDE);
        end else begin
            cols_eff = SZW'(cfg_cols_reg);
        end
    end

    assign n_eff    = LOAD_W'(rows_eff) * LOAD_W'(cols_eff);
    assign load_inc = load_count_reg + LOAD_W'(1);

    // manhattan distance from the output position to the scanned position
    assign dr       = (r_reg >= rr_reg) ? (r_reg - rr_reg) : (rr_reg - r_reg);
    assign dc       = (c_reg >= cc_reg) ? (c_reg - cc_reg) : (cc_reg - c_reg);
    assign man_dist = DIST_W'(dr) + DIST_W'(dc);

    assign inner_last = (rr_reg == SW'(rows_reg - SZW'(1)))
                     && (cc_reg == SW'(cols_reg - SZW'(1)));
    assign pos_last   = (r_reg == SW'(rows_reg - SZW'(1)))
                     && (c_reg == SW'(cols_reg - SZW'(1)));

    // read data lands in the cycle after its address, with its hit flag
    assign sum_acc = (pend_reg && hit_reg) ? (sum_reg + SUM_W'(rd_data_reg)) : sum_reg;
    assign cnt_acc = (pend_reg && hit_reg) ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    // restoring divider step: shift in the next dividend bit
    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        d_next          = d_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        rr_next         = rr_reg;
        cc_next         = cc_reg;
        addr_next       = addr_reg;
        pend_next       = 1'b0;
        hit_next        = hit_reg;
        sum_next        = sum_acc;
        cnt_next        = cnt_acc;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        step_next       = step_reg;
        m_average_next  = m_average_reg;
        m_is_last_next  = m_is_last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    mem_we = 1'b1;
                    if (load_inc >= n_eff) begin
                        // region complete: freeze sizes and radius
                        load_count_next = '0;
                        rows_next       = rows_eff;
                        cols_next       = cols_eff;
                        d_next          = ((rows_eff >> 1) < (cols_eff >> 1))
                                        ? (rows_eff >> 1) : (cols_eff >> 1);
                        r_next          = '0;
                        c_next          = '0;
                        rr_next         = '0;
                        cc_next         = '0;
                        addr_next       = '0;
                        sum_next        = '0;
                        cnt_next        = '0;
                        state_next      = ST_SCAN;
                    end else begin
                        load_count_next = load_inc;
                    end
                end
            end
            ST_SCAN: begin
                // one memory read per cycle over the whole region
                pend_next = 1'b1;
                hit_next  = (man_dist <= DIST_W'(d_reg));
                if (inner_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    addr_next = addr_reg + AW'(1);
                    if (cc_reg == SW'(cols_reg - SZW'(1))) begin
                        cc_next = '0;
                        rr_next = rr_reg + SW'(1);
                    end else begin
                        cc_next = cc_reg + SW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                // last read accumulated here; load divider with the rounding bias
                quo_next   = sum_acc + SUM_W'(cnt_acc >> 1);
                den_next   = cnt_acc;
                rem_next   = '0;
                step_next  = '0;
                sum_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = CNT_W'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next   = 1'b1;
                    m_average_next = quo_reg[PIXEL_W-1:0];
                    m_is_last_next = pos_last;
                    if (pos_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        rr_next    = '0;
                        cc_next    = '0;
                        addr_next  = '0;
                        state_next = ST_SCAN;
                        if (c_reg == SW'(cols_reg - SZW'(1))) begin
                            c_next = '0;
                            r_next = r_reg + SW'(1);
                        end else begin
                            c_next = c_reg + SW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_rows_reg <= SIDE_RESET;
            cfg_cols_reg <= SIDE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROWS: cfg_rows_reg <= cfg_data;
                REG_COLS: cfg_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            pend_reg       <= pend_next;
            m_valid_reg    <= m_valid_next;
        end
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        d_reg         <= d_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        rr_reg        <= rr_next;
        cc_reg        <= cc_next;
        addr_reg      <= addr_next;
        hit_reg       <= hit_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        step_reg      <= step_next;
        m_average_reg <= m_average_next;
        m_is_last_reg <= m_is_last_next;
    end

    // region memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            region_mem[load_count_reg[AW-1:0]] <= s_pixel;
        end
        rd_data_reg <= region_mem[addr_reg];
    end

    // ports
    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;
    assign m_is_last = m_is_last_reg;

    // checks
    `DNMB_ASSERT_IMP(a_load_in_range, aclk, aresetn, 1'b1,
        load_count_reg < LOAD_W'(DEPTH), "load count beyond region memory")
    `DNMB_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV,
        den_reg != '0, "empty neighbourhood at divide")
    `DNMB_ASSERT_IMP(a_quo_fits, aclk, aresetn, state_reg == ST_EMIT,
        quo_reg[SUM_W-1:PIXEL_W] == '0, "mean exceeds pixel range")
    `DNMB_ASSERT_NXT(a_last_reopens, aclk, aresetn, emit_fire && pos_last,
        s_ready && m_valid && m_is_last, "last result does not reopen loading")

endmodule
